>>> hw/rtl/btog_pkg.sv
package btog_pkg;

  localparam int unsigned FW_W      = 11;
  localparam int unsigned CELLS_W   = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned ROW_W     = 4;
  localparam int unsigned BITS_W    = 16;

  localparam int unsigned MAX_CELLS_PER_SIDE_DEF = 16;
  localparam int unsigned MAX_FRAME_WIDTH_DEF    = 1024;

  localparam int unsigned FRAME_WIDTH_RST    = 300;
  localparam int unsigned CELLS_PER_SIDE_RST = 4;

  localparam logic [PIX_W-1:0] SET_PIXEL = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_SIDE = 1'd1;

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_LOAD = 3'b010,
    DIV_RUN  = 3'b100
  } div_state_e;

endpackage

>>> hw/rtl/binary_tile_occupancy_grid.sv
// After the end-of-frame word is accepted the row emitter is armed, then the
// word for tile row 0 is registered at the output; further rows follow one per
// cycle while out_ready_i is high. Throughput: one pixel word per cycle. A frame-end
// word waits while the previous frame's rows are still being sent; a register write
// stalls input while the serial divider finds the tile side.
// Reset: 300 pixel frame, 4 tiles a side, tile side 75, counters and grid clear.
module binary_tile_occupancy_grid
  import btog_pkg::*;
#(
  parameter int unsigned MAX_CELLS_PER_SIDE = MAX_CELLS_PER_SIDE_DEF,
  parameter int unsigned MAX_FRAME_WIDTH    = MAX_FRAME_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      pixel_value_i,
  input  logic                  end_of_frame_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ROW_W-1:0]      grid_row_o,
  output logic [BITS_W-1:0]     row_bits_o,
  output logic                  last_row_o
);

  localparam int unsigned EW  = $clog2(MAX_FRAME_WIDTH + 1);
  localparam int unsigned NW  = $clog2(MAX_CELLS_PER_SIDE + 1);
  localparam int unsigned IW  = (MAX_CELLS_PER_SIDE > 1) ? $clog2(MAX_CELLS_PER_SIDE) : 1;
  localparam int unsigned SW  = $clog2(EW + 1);
  localparam int unsigned MC  = MAX_CELLS_PER_SIDE;
  localparam int unsigned W_RST =
    (FRAME_WIDTH_RST > MAX_FRAME_WIDTH) ? MAX_FRAME_WIDTH : FRAME_WIDTH_RST;
  localparam int unsigned C_RST =
    (CELLS_PER_SIDE_RST > MAX_CELLS_PER_SIDE) ? MAX_CELLS_PER_SIDE : CELLS_PER_SIDE_RST;
  localparam int unsigned TS_RST = W_RST / C_RST;

  typedef logic [MC-1:0] occ_row_t;

  logic [FW_W-1:0]    fw_q;
  logic [CELLS_W-1:0] cells_q;
  logic [EW-1:0]      eff_w;
  logic [NW-1:0]      eff_c;

  div_state_e         div_state_q, div_state_d;
  logic [EW-1:0]      quo_q, quo_d;
  logic [NW-1:0]      rem_q, rem_d;
  logic [NW:0]        rem_sh;
  logic [SW-1:0]      step_q, step_d;
  logic [EW-1:0]      div_res_q, div_res_d;

  logic [EW-1:0]      col_q, row_q, csub_q, rsub_q, tile_q;
  logic [NW-1:0]      tcol_q, trow_q;
  occ_row_t           occ_q [MC];
  occ_row_t           sh_q [MC];

  logic               emit_act_q;
  logic [NW-1:0]      emit_idx_q, emit_n_q;

  logic               out_valid_q, last_row_q;
  logic [ROW_W-1:0]   grid_row_q;
  logic [BITS_W-1:0]  row_bits_q;

  logic               in_acc, frame_start, hit, col_wrap, row_wrap, col_step, row_step;
  logic               emit_load, emit_last;
  logic [EW-1:0]      ts;
  logic [EW:0]        col_inc, row_inc;
  logic [NW-1:0]      tcol_inc, trow_inc;
  occ_row_t           col_hot, cell_mask;

  assign eff_w = (fw_q == '0) ? EW'(1) :
                 ((32'(fw_q) > MAX_FRAME_WIDTH) ? EW'(MAX_FRAME_WIDTH) : EW'(fw_q));
  assign eff_c = (cells_q == '0) ? NW'(1) :
                 ((32'(cells_q) > MAX_CELLS_PER_SIDE) ? NW'(MAX_CELLS_PER_SIDE)
                                                      : NW'(cells_q));

  // serial restoring divider, one quotient bit a cycle
  assign rem_sh = {rem_q, quo_q[EW-1]};

  always_comb begin
    div_state_d = div_state_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    step_d      = step_q;
    div_res_d   = div_res_q;
    unique case (div_state_q)
      DIV_IDLE: ;
      DIV_LOAD: begin
        quo_d       = eff_w;
        rem_d       = '0;
        step_d      = '0;
        div_state_d = DIV_RUN;
      end
      DIV_RUN: begin
        if (rem_sh >= {1'b0, eff_c}) begin
          rem_d = NW'(rem_sh - {1'b0, eff_c});
          quo_d = {quo_q[EW-2:0], 1'b1};
        end else begin
          rem_d = NW'(rem_sh);
          quo_d = {quo_q[EW-2:0], 1'b0};
        end
        step_d = step_q + SW'(1);
        if (step_q == SW'(EW - 1)) begin
          div_res_d   = quo_d;
          div_state_d = DIV_IDLE;
        end
      end
      default: div_state_d = DIV_IDLE;
    endcase
    if (cfg_we_i) begin
      div_state_d = DIV_LOAD;
    end
  end

  assign in_ready_o  = (div_state_q == DIV_IDLE) && !(end_of_frame_i && emit_act_q);
  assign in_acc      = in_valid_i && in_ready_o;
  assign frame_start = (col_q == '0) && (row_q == '0);
  assign ts          = frame_start ? div_res_q : tile_q;

  assign hit = (pixel_value_i == SET_PIXEL) && (ts != '0) &&
               (tcol_q < eff_c) && (trow_q < eff_c);
  assign col_hot = hit ? (MC'(1) << tcol_q) : '0;

  assign col_inc  = {1'b0, col_q} + (EW+1)'(1);
  assign row_inc  = {1'b0, row_q} + (EW+1)'(1);
  assign col_wrap = col_inc >= {1'b0, eff_w};
  assign row_wrap = row_inc >= {1'b0, eff_w};
  assign col_step = ({1'b0, csub_q} + (EW+1)'(1)) == {1'b0, ts};
  assign row_step = ({1'b0, rsub_q} + (EW+1)'(1)) == {1'b0, ts};
  assign tcol_inc = (tcol_q == NW'(MC)) ? tcol_q : tcol_q + NW'(1);
  assign trow_inc = (trow_q == NW'(MC)) ? trow_q : trow_q + NW'(1);

  always_comb begin
    for (int i = 0; i < MC; i++) begin
      cell_mask[i] = (32'(eff_c) > i);
    end
  end

  assign emit_load = emit_act_q && (!out_valid_q || out_ready_i);
  assign emit_last = (emit_idx_q + NW'(1)) == emit_n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q        <= FW_W'(FRAME_WIDTH_RST);
      cells_q     <= CELLS_W'(CELLS_PER_SIDE_RST);
      div_state_q <= DIV_IDLE;
      div_res_q   <= EW'(TS_RST);
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FRAME_WIDTH:    fw_q    <= cfg_data_i;
          CFG_CELLS_PER_SIDE: cells_q <= CELLS_W'(cfg_data_i);
          default: ;
        endcase
      end
      div_state_q <= div_state_d;
      div_res_q   <= div_res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    step_q <= step_d;
  end

  // advance pixel and tile counters, accumulate occupancy, clear both at frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      csub_q <= '0;
      rsub_q <= '0;
      tcol_q <= '0;
      trow_q <= '0;
      tile_q <= EW'(TS_RST);
      for (int r = 0; r < MC; r++) begin
        occ_q[r] <= '0;
      end
    end else if (in_acc) begin
      tile_q <= ts;
      if (end_of_frame_i) begin
        col_q  <= '0;
        row_q  <= '0;
        csub_q <= '0;
        rsub_q <= '0;
        tcol_q <= '0;
        trow_q <= '0;
        for (int r = 0; r < MC; r++) begin
          occ_q[r] <= '0;
        end
      end else begin
        for (int r = 0; r < MC; r++) begin
          if (trow_q == NW'(r)) begin
            occ_q[r] <= occ_q[r] | col_hot;
          end
        end
        if (col_wrap) begin
          col_q  <= '0;
          csub_q <= '0;
          tcol_q <= '0;
          if (row_wrap) begin
            row_q  <= '0;
            rsub_q <= '0;
            trow_q <= '0;
          end else begin
            row_q <= EW'(row_inc);
            if (row_step) begin
              rsub_q <= '0;
              trow_q <= trow_inc;
            end else begin
              rsub_q <= rsub_q + EW'(1);
            end
          end
        end else begin
          col_q <= EW'(col_inc);
          if (col_step) begin
            csub_q <= '0;
            tcol_q <= tcol_inc;
          end else begin
            csub_q <= csub_q + EW'(1);
          end
        end
      end
    end
  end

  // hold the finished grid while its rows drain
  always_ff @(posedge clk_i) begin
    if (in_acc && end_of_frame_i) begin
      for (int r = 0; r < MC; r++) begin
        if (trow_q == NW'(r)) begin
          sh_q[r] <= (occ_q[r] | col_hot) & cell_mask;
        end else begin
          sh_q[r] <= occ_q[r] & cell_mask;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_act_q  <= 1'b0;
      emit_idx_q  <= '0;
      emit_n_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc && end_of_frame_i) begin
        emit_act_q <= 1'b1;
        emit_idx_q <= '0;
        emit_n_q   <= eff_c;
      end else if (emit_load) begin
        emit_idx_q <= emit_idx_q + NW'(1);
        if (emit_last) begin
          emit_act_q <= 1'b0;
        end
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      grid_row_q <= ROW_W'(emit_idx_q);
      row_bits_q <= BITS_W'(sh_q[emit_idx_q[IW-1:0]]);
      last_row_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign grid_row_o  = grid_row_q;
  assign row_bits_o  = row_bits_q;
  assign last_row_o  = last_row_q;

`ifndef SYNTHESIS
  a_no_input_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_state_q != DIV_IDLE) |-> !in_ready_o)
    else $error("input taken while tile side is being computed");

  a_no_frame_end_while_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && emit_act_q) |-> !end_of_frame_i)
    else $error("frame end accepted while previous grid still draining");

  a_counters_clear_at_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_frame_i) |=> (col_q == '0) && (row_q == '0) && emit_act_q)
    else $error("counters not cleared after frame end");

  a_last_row_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_load && emit_last) |=> (last_row_o && out_valid_o && !emit_act_q))
    else $error("final grid row not flagged");
`endif

endmodule

>>> tb/sv/btog_occupancy_checker.sv
module btog_occupancy_checker
  import btog_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [PIX_W-1:0]      pixel_value_i,
  input  logic                  end_of_frame_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [ROW_W-1:0]      grid_row_i,
  input  logic [BITS_W-1:0]     row_bits_i,
  input  logic                  last_row_i,
  output int unsigned           fail_count_o,
  output int unsigned           rows_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [BITS_W-1:0] bits;
    logic              last;
  } tile_row_t;

  logic [FW_W-1:0]    frame_width_q;
  logic [CELLS_W-1:0] cells_q;
  logic [FW_W-1:0]    col_q;
  logic [FW_W-1:0]    row_q;
  logic [FW_W-1:0]    side_q;
  logic [BITS_W-1:0]  occupancy_q [MAX_CELLS_PER_SIDE_DEF];
  tile_row_t          rows_due [$];

  function automatic int unsigned live_width();
    if (frame_width_q == '0) return 1;
    if (frame_width_q > MAX_FRAME_WIDTH_DEF) return MAX_FRAME_WIDTH_DEF;
    return frame_width_q;
  endfunction

  function automatic int unsigned live_cells();
    if (cells_q == '0) return 1;
    if (cells_q > MAX_CELLS_PER_SIDE_DEF) return MAX_CELLS_PER_SIDE_DEF;
    return cells_q;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t row word mismatch on %s: got 'h%0h, want 'h%0h", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic track_pixel(input logic [PIX_W-1:0] pix, input logic eof);
    int unsigned       width;
    int unsigned       cells;
    int unsigned       tc;
    int unsigned       tr;
    int unsigned       r;
    logic [BITS_W-1:0] mask;
    tile_row_t         due;
    width = live_width();
    cells = live_cells();
    // latch the tile side at frame start only
    if (col_q == '0 && row_q == '0) side_q = FW_W'(width / cells);
    if (pix == SET_PIXEL && side_q != '0) begin
      tc = col_q / side_q;
      tr = row_q / side_q;
      if (tc < cells && tr < cells) occupancy_q[tr][tc] = 1'b1;
    end
    col_q = col_q + 1'b1;
    if (col_q >= width) begin
      col_q = '0;
      row_q = row_q + 1'b1;
      if (row_q >= width) row_q = '0;
    end
    if (eof) begin
      mask = (cells >= BITS_W) ? '1 : BITS_W'((32'd1 << cells) - 1);
      for (r = 0; r < cells; r++) begin
        due.row  = ROW_W'(r);
        due.bits = occupancy_q[r] & mask;
        due.last = (r + 1 == cells);
        rows_due.push_back(due);
      end
      foreach (occupancy_q[i]) occupancy_q[i] = '0;
      col_q = '0;
      row_q = '0;
    end
  endtask

  task automatic check_row();
    tile_row_t due;
    if (rows_due.size() == 0) begin
      flag_mismatch("unexpected word, grid_row", grid_row_i, '0);
    end else begin
      due = rows_due.pop_front();
      if (grid_row_i !== due.row) flag_mismatch("grid_row", grid_row_i, due.row);
      if (row_bits_i !== due.bits) flag_mismatch("row_bits", row_bits_i, due.bits);
      if (last_row_i !== due.last) flag_mismatch("last_row", last_row_i, due.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q = FW_W'(FRAME_WIDTH_RST);
      cells_q       = CELLS_W'(CELLS_PER_SIDE_RST);
      col_q         = '0;
      row_q         = '0;
      side_q        = FW_W'(FRAME_WIDTH_RST / CELLS_PER_SIDE_RST);
      foreach (occupancy_q[i]) occupancy_q[i] = '0;
      rows_due.delete();
      fail_count_o  = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FRAME_WIDTH) begin
          frame_width_q = cfg_data_i[FW_W-1:0];
        end else if (cfg_idx_i == CFG_CELLS_PER_SIDE) begin
          cells_q = cfg_data_i[CELLS_W-1:0];
        end
      end
      if (in_valid_i && in_ready_i) track_pixel(pixel_value_i, end_of_frame_i);
      if (out_valid_i && out_ready_i) check_row();
    end
    rows_due_o = rows_due.size();
  end

endmodule

>>> tb/sv/tb_binary_tile_occupancy_grid.sv
module tb_binary_tile_occupancy_grid
  import btog_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx      = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel_value  = '0;
  logic                  end_of_frame = 1'b0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [ROW_W-1:0]      grid_row;
  logic [BITS_W-1:0]     row_bits;
  logic                  last_row;
  logic                  calm         = 1'b0;
  int unsigned           fail_count;
  int unsigned           rows_due;
  int unsigned           cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  binary_tile_occupancy_grid dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .pixel_value_i  (pixel_value),
    .end_of_frame_i (end_of_frame),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .grid_row_o     (grid_row),
    .row_bits_o     (row_bits),
    .last_row_o     (last_row)
  );

  btog_occupancy_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .pixel_value_i  (pixel_value),
    .end_of_frame_i (end_of_frame),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .grid_row_i     (grid_row),
    .row_bits_i     (row_bits),
    .last_row_i     (last_row),
    .fail_count_o   (fail_count),
    .rows_due_o     (rows_due)
  );

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 13);
  end

  function automatic logic [PIX_W-1:0] mask_pixel();
    return ($urandom_range(3) == 0) ? SET_PIXEL : PIX_W'($urandom_range(255));
  endfunction

  task automatic send_word(input logic [PIX_W-1:0] pix, input logic eof);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    pixel_value  <= pix;
    end_of_frame <= eof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_run(input int unsigned count, input logic eof_last);
    int unsigned i;
    for (i = 0; i < count; i++) send_word(mask_pixel(), eof_last && (i + 1 == count));
  endtask

  // hold input until every row word is back, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input int unsigned width, input int unsigned cells);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_FRAME_WIDTH;
    cfg_data <= CFG_DATA_W'(width);
    @(posedge clk);
    cfg_idx  <= CFG_CELLS_PER_SIDE;
    cfg_data <= CFG_DATA_W'(($urandom_range(63) << CELLS_W) | (cells & 5'h1f));
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned done_items;
    int unsigned width;
    int unsigned cells;
    int unsigned eff;
    int unsigned count;
    int unsigned pick;
    logic        wide;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    send_word(SET_PIXEL, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hfe, 1'b1);
    settle();

    write_config(0, 0);
    send_word(SET_PIXEL, 1'b1);
    settle();

    // tiles narrower than a pixel
    write_config(2, 5);
    repeat (3) send_word(SET_PIXEL, 1'b0);
    send_word(SET_PIXEL, 1'b1);
    settle();

    write_config(2047, 31);
    send_word(SET_PIXEL, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h7f, 1'b1);
    settle();

    // shrink the width mid-frame with the column already past it
    write_config(4, 2);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(SET_PIXEL, 1'b0);
    settle();
    write_config(2, 4);
    send_word(SET_PIXEL, 1'b0);
    send_word(SET_PIXEL, 1'b1);
    settle();

    // run past the frame end so both counters wrap
    write_config(2, 1);
    send_run(5, 1'b0);
    send_word(SET_PIXEL, 1'b1);
    settle();

    done_items = 0;
    while (done_items < 330) begin
      calm <= (done_items >= 120 && done_items < 200);
      pick = $urandom_range(7);
      wide = (pick < 3);
      if (pick == 0) begin
        case ($urandom_range(4))
          0: width = 0;
          1: width = 1;
          2: width = MAX_FRAME_WIDTH_DEF;
          3: width = 2047;
          default: width = $urandom_range(1025, 2046);
        endcase
        case ($urandom_range(4))
          0: cells = 0;
          1: cells = 1;
          2: cells = MAX_CELLS_PER_SIDE_DEF;
          3: cells = 31;
          default: cells = $urandom_range(17, 30);
        endcase
      end else if (pick < 3) begin
        width = $urandom_range(7, 16);
        cells = $urandom_range(1, 16);
      end else begin
        width = $urandom_range(1, 6);
        cells = $urandom_range(0, 8);
      end
      eff = (width == 0) ? 1 : ((width > MAX_FRAME_WIDTH_DEF) ? MAX_FRAME_WIDTH_DEF : width);
      write_config(width, cells);
      repeat ($urandom_range(1, 4)) begin
        if (wide) begin
          count = $urandom_range(1, 40);
        end else begin
          case ($urandom_range(5))
            0: count = $urandom_range(1, eff * eff);
            1: count = eff * eff + $urandom_range(1, 2 * eff);
            default: count = eff * eff;
          endcase
        end
        send_run(count, 1'b1);
        done_items += count;
      end
      settle();
    end

    calm <= 1'b0;
    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && rows_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
